// ----- rtl/bmidi_pkg.sv -----
// shared types, constants and helpers for the ble-midi to serial midi converter
// no dependencies
package bmidi_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END  = 8'hF7;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_ACT_SENSE  = 8'hFE;
    localparam logic [7:0] ST_NONE       = 8'h00;

    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS = 4'hA;
    localparam logic [3:0] HI_CTRL       = 4'hB;
    localparam logic [3:0] HI_PITCH      = 4'hE;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TIME    = 3'd1,
        PH_STATUS  = 3'd2,
        PH_DATA1   = 3'd3,
        PH_DATA2   = 3'd4,
        PH_SX_DATA = 3'd5,
        PH_SX_MARK = 3'd6
    } phase_t;

    // results of one request: up to two bytes, last flag implied by count
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } emit_t;

    function automatic logic is_channel(input logic [7:0] s);
        return (s inside {[8'h80:8'hEF]});
    endfunction

    function automatic logic two_data(input logic [7:0] s);
        return (s[7:4] == HI_NOTE_OFF) || (s[7:4] == HI_NOTE_ON) ||
               (s[7:4] == HI_POLY_PRESS) || (s[7:4] == HI_CTRL) ||
               (s[7:4] == HI_PITCH);
    endfunction

    function automatic logic is_fwd_realtime(input logic [7:0] b);
        return (b == ST_CLOCK) || (b == ST_ACT_SENSE);
    endfunction

endpackage

// ----- rtl/bmidi_parser.sv -----
// packet byte parser: phase, running status and sysex state, result bytes per request
// depends on bmidi_pkg
module bmidi_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           rx_byte,
    input  logic                 packet_start,
    output bmidi_pkg::emit_t     emit
);
    import bmidi_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] rs_reg, rs_next;
    logic       sx_reg, sx_next;

    always_comb
    begin
        phase_next = phase_reg;
        rs_next    = rs_reg;
        sx_next    = sx_reg;
        emit       = '0;
        if (packet_start)
        begin
            phase_next = sx_reg ? PH_SX_DATA : PH_TIME;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    phase_next = PH_HEADER;
                end
                PH_TIME:
                begin
                    phase_next = PH_STATUS;
                end
                PH_STATUS:
                begin
                    if (!rx_byte[7])
                    begin
                        if (is_channel(rs_reg))
                        begin
                            emit.count       = 2'd2;
                            emit.first_byte  = rs_reg;
                            emit.second_byte = rx_byte;
                            phase_next       = two_data(rs_reg) ? PH_DATA2 : PH_TIME;
                        end
                    end
                    else if (is_fwd_realtime(rx_byte))
                    begin
                        emit.count      = 2'd1;
                        emit.first_byte = rx_byte;
                        phase_next      = PH_TIME;
                    end
                    else if (is_channel(rx_byte))
                    begin
                        rs_next    = rx_byte;
                        phase_next = PH_DATA1;
                    end
                    else if (rx_byte == ST_SYSEX)
                    begin
                        emit.count      = 2'd1;
                        emit.first_byte = ST_SYSEX;
                        rs_next         = ST_NONE;
                        sx_next         = 1'b1;
                        phase_next      = PH_SX_DATA;
                    end
                    else
                    begin
                        rs_next    = ST_NONE;
                        phase_next = PH_TIME;
                    end
                end
                PH_DATA1:
                begin
                    if (rx_byte[7])
                    begin
                        phase_next = PH_STATUS;
                    end
                    else
                    begin
                        emit.count       = 2'd2;
                        emit.first_byte  = rs_reg;
                        emit.second_byte = rx_byte;
                        phase_next       = two_data(rs_reg) ? PH_DATA2 : PH_TIME;
                    end
                end
                PH_DATA2:
                begin
                    if (rx_byte[7])
                    begin
                        phase_next = PH_STATUS;
                    end
                    else
                    begin
                        emit.count      = 2'd1;
                        emit.first_byte = rx_byte;
                        phase_next      = PH_TIME;
                    end
                end
                PH_SX_DATA:
                begin
                    if (rx_byte[7])
                    begin
                        phase_next = PH_SX_MARK;
                    end
                    else
                    begin
                        emit.count      = 2'd1;
                        emit.first_byte = rx_byte;
                    end
                end
                PH_SX_MARK:
                begin
                    if (rx_byte == ST_SYSEX_END)
                    begin
                        emit.count      = 2'd1;
                        emit.first_byte = ST_SYSEX_END;
                        sx_next         = 1'b0;
                        rs_next         = ST_NONE;
                        phase_next      = PH_TIME;
                    end
                    else
                    begin
                        if (is_fwd_realtime(rx_byte))
                        begin
                            emit.count      = 2'd1;
                            emit.first_byte = rx_byte;
                        end
                        phase_next = PH_SX_DATA;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            rs_reg    <= ST_NONE;
            sx_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            rs_reg    <= rs_next;
            sx_reg    <= sx_next;
        end
    end

    // sysex only lives in the sysex phases
    assert property (@(posedge clk) disable iff (!rst_n)
        sx_reg |-> (phase_reg == PH_SX_DATA || phase_reg == PH_SX_MARK))
        else $error("sysex flag set outside sysex phases");

    // data phases always run on a channel status
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA1 || phase_reg == PH_DATA2) |-> is_channel(rs_reg))
        else $error("data phase without channel running status");

    // a channel status byte alone never produces output
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !packet_start && phase_reg == PH_STATUS && is_channel(rx_byte))
        |-> (emit.count == 2'd0))
        else $error("channel status emitted on its own");

endmodule

// ----- rtl/bmidi_outq.sv -----
// small output queue: takes up to two bytes per request, hands out one per cycle while out_stall is low
// depends on bmidi_pkg
module bmidi_outq
#(
    parameter int DEPTH = bmidi_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bmidi_pkg::emit_t emit,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       midi_byte,
    output logic             last_of_run
);
    import bmidi_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    data_reg  [DEPTH];
    logic [7:0]    data_next [DEPTH];
    logic [7:0]    data_shift[DEPTH];
    logic          last_reg  [DEPTH];
    logic          last_next [DEPTH];
    logic          last_shift[DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] base;
    logic [CW-1:0] add;
    logic          pop;

    assign out_valid   = (count_reg != '0);
    assign midi_byte   = data_reg[0];
    assign last_of_run = last_reg[0];
    assign full        = (count_reg >= CW'(DEPTH - 1));
    assign pop         = out_valid && !out_stall;
    assign add         = push ? CW'(emit.count) : '0;
    assign base        = count_reg - (pop ? CW'(1) : CW'(0));
    assign count_next  = base + add;

    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            data_shift[i] = data_reg[i + 1];
            last_shift[i] = last_reg[i + 1];
        end
        data_shift[DEPTH - 1] = data_reg[DEPTH - 1];
        last_shift[DEPTH - 1] = last_reg[DEPTH - 1];

        for (int i = 0; i < DEPTH; i++)
        begin
            data_next[i] = pop ? data_shift[i] : data_reg[i];
            last_next[i] = pop ? last_shift[i] : last_reg[i];
            if (CW'(i) == base && add != '0)
            begin
                data_next[i] = emit.first_byte;
                last_next[i] = (emit.count == 2'd1);
            end
            else if (CW'(i) == base + CW'(1) && add == CW'(2))
            begin
                data_next[i] = emit.second_byte;
                last_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            data_reg[i] <= data_next[i];
            last_reg[i] <= last_next[i];
        end
    end

    // occupancy bound
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("output queue overflow");

    // a head byte that is not last always has its partner queued behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> (count_reg >= CW'(2)))
        else $error("first byte of a pair without its second byte");

    // occupancy grows by two on a pair push without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && emit.count == 2'd2 && !pop) |=> (count_reg == $past(count_reg) + CW'(2)))
        else $error("pair push lost in output queue");

endmodule

// ----- rtl/ble_midi_packet_to_serial_midi.sv -----
// top level of the ble-midi packet to serial midi byte converter
// depends on bmidi_pkg, bmidi_parser, bmidi_outq
//
// Takes one BLE-MIDI packet byte per request (packet_start marks the header)
// and produces plain serial MIDI bytes, one per output request, with
// last_of_run set on the final byte caused by an input byte. An input byte
// is taken in the cycle it is offered unless in_stall is high; the parser
// state updates at once and its zero, one or two result bytes enter a
// QUEUE_DEPTH-entry output queue. in_stall is raised while the queue has
// fewer than two free entries, so input runs at one byte per cycle as long
// as the output side drains one byte per cycle; a status-plus-data pair
// puts two bytes into the queue, which registers them before output.
module ble_midi_packet_to_serial_midi
#(
    parameter int QUEUE_DEPTH = bmidi_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       packet_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] midi_byte,
    output logic       last_of_run
);
    import bmidi_pkg::*;

    emit_t emit;
    logic  full;
    logic  take;

    assign in_stall = full;
    assign take     = in_valid && !full;

    bmidi_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .rx_byte      (rx_byte),
        .packet_start (packet_start),
        .emit         (emit)
    );

    bmidi_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (take),
        .emit        (emit),
        .full        (full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .midi_byte   (midi_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ----- verif/ble_midi_packet_to_serial_midi_tb.sv -----
// testbench for ble_midi_packet_to_serial_midi: directed and random ble-midi packets
// depends on bmidi_pkg and the converter rtl; a scoreboard class predicts the midi bytes
module ble_midi_packet_to_serial_midi_tb;
    import bmidi_pkg::*;

    localparam logic [3:0] HI_PROG       = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;
    localparam int         RANDOM_ITEMS  = 1150;
    localparam int         CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       tail;
    } midi_out_t;

    class midi_scoreboard;
        phase_t     phase;
        logic [7:0] run_status;
        logic       sysex_open;
        midi_out_t  fresh[$];
        midi_out_t  pending_bytes[$];
        int         mismatches;
        int         compared;
        int         sysex_closed;

        function new();
            phase        = PH_HEADER;
            run_status   = ST_NONE;
            sysex_open   = 1'b0;
            mismatches   = 0;
            compared     = 0;
            sysex_closed = 0;
        endfunction

        function logic chan_status(logic [7:0] s);
            return s[7] && (s < ST_SYSEX);
        endfunction

        function void push_byte(logic [7:0] b);
            fresh.push_back('{data: b, tail: 1'b0});
        endfunction

        // first data byte goes out together with the status
        function void open_message(logic [7:0] d);
            push_byte(run_status);
            push_byte(d);
            phase = (run_status[7:4] == HI_PROG || run_status[7:4] == HI_CHAN_PRESS)
                    ? PH_TIME : PH_DATA2;
        endfunction

        function void note_request(logic [7:0] b, logic start);
            fresh.delete();
            if (start)
            begin
                phase = sysex_open ? PH_SX_DATA : PH_TIME;
            end
            else
            begin
                case (phase)
                    PH_TIME:
                    begin
                        phase = PH_STATUS;
                    end
                    PH_STATUS:
                    begin
                        if (!b[7])
                        begin
                            if (chan_status(run_status))
                                open_message(b);
                        end
                        else if (b == ST_CLOCK || b == ST_ACT_SENSE)
                        begin
                            push_byte(b);
                            phase = PH_TIME;
                        end
                        else if (chan_status(b))
                        begin
                            run_status = b;
                            phase      = PH_DATA1;
                        end
                        else if (b == ST_SYSEX)
                        begin
                            push_byte(b);
                            run_status = ST_NONE;
                            sysex_open = 1'b1;
                            phase      = PH_SX_DATA;
                        end
                        else
                        begin
                            run_status = ST_NONE;
                            phase      = PH_TIME;
                        end
                    end
                    PH_DATA1:
                    begin
                        if (b[7])
                            phase = PH_STATUS;
                        else
                            open_message(b);
                    end
                    PH_DATA2:
                    begin
                        if (!b[7])
                            push_byte(b);
                        phase = b[7] ? PH_STATUS : PH_TIME;
                    end
                    PH_SX_DATA:
                    begin
                        if (b[7])
                            phase = PH_SX_MARK;
                        else
                            push_byte(b);
                    end
                    PH_SX_MARK:
                    begin
                        if (b == ST_SYSEX_END)
                        begin
                            push_byte(b);
                            sysex_open = 1'b0;
                            run_status = ST_NONE;
                            phase      = PH_TIME;
                            sysex_closed++;
                        end
                        else
                        begin
                            if (b == ST_CLOCK || b == ST_ACT_SENSE)
                                push_byte(b);
                            phase = PH_SX_DATA;
                        end
                    end
                    default:
                    begin
                        phase = PH_HEADER;
                    end
                endcase
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].tail = 1'b1;
            foreach (fresh[i])
                pending_bytes.push_back(fresh[i]);
        endfunction

        function void check_byte(logic [7:0] b, logic tail);
            midi_out_t want;
            compared++;
            if (pending_bytes.size() == 0)
            begin
                $error("midi_byte: expected nothing, actual %h", b);
                mismatches++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (b !== want.data)
                begin
                    $error("midi_byte: expected %h, actual %h", want.data, b);
                    mismatches++;
                end
                if (tail !== want.tail)
                begin
                    $error("last_of_run: expected %b, actual %b", want.tail, tail);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte      = 8'h00;
    logic       packet_start = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] midi_byte;
    logic       last_of_run;

    midi_scoreboard sb;
    logic           quiet      = 1'b0;
    int             sent       = 0;
    int             cycles     = 0;
    int             stall_left = 0;

    ble_midi_packet_to_serial_midi dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .packet_start (packet_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .midi_byte    (midi_byte),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] stamp();
        return {1'b1, 7'($urandom)};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        rx_byte      <= b;
        packet_start <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(b, start);
        sent++;
    endtask

    // always waits on the clock before checking so the idle drive settles first
    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.pending_bytes.size() != 0);
    endtask

    // sysex payload with marked bytes, closed most of the time
    task automatic sysex_body();
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    send_byte(stamp(), 1'b0);
                    send_byte($urandom_range(0, 1) ? ST_CLOCK : ST_ACT_SENSE, 1'b0);
                end
                1:
                begin
                    send_byte(stamp(), 1'b0);
                    send_byte(8'($urandom_range(8'h80, 8'hF6)), 1'b0);
                end
                default:
                begin
                    send_byte({1'b0, 7'($urandom)}, 1'b0);
                end
            endcase
        end
        if ($urandom_range(0, 9) < 7)
        begin
            send_byte(stamp(), 1'b0);
            send_byte(ST_SYSEX_END, 1'b0);
        end
    endtask

    task automatic random_packet();
        int         kind;
        int         n_data;
        logic [7:0] st;
        send_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)}, 1'b1);
        if (sb.sysex_open)
            sysex_body();
        repeat ($urandom_range(1, 5))
        begin
            kind = $urandom_range(0, 99);
            if (sb.sysex_open)
            begin
                // packet ends while sysex is still open
            end
            else if (kind < 50)
            begin
                send_byte(stamp(), 1'b0);
                if (!(sb.run_status[7] && $urandom_range(0, 2) == 0))
                begin
                    st = {4'($urandom_range(8, 14)), 4'($urandom)};
                    send_byte(st, 1'b0);
                end
                st     = sb.run_status;
                n_data = (st[7:4] == HI_PROG || st[7:4] == HI_CHAN_PRESS) ? 1 : 2;
                repeat (n_data)
                    send_byte(($urandom_range(0, 19) == 0) ? stamp() : {1'b0, 7'($urandom)},
                              1'b0);
            end
            else if (kind < 60)
            begin
                send_byte(stamp(), 1'b0);
                send_byte($urandom_range(0, 1) ? ST_CLOCK : ST_ACT_SENSE, 1'b0);
            end
            else if (kind < 75)
            begin
                send_byte(stamp(), 1'b0);
                send_byte(ST_SYSEX, 1'b0);
                sysex_body();
            end
            else if (kind < 85)
            begin
                send_byte(stamp(), 1'b0);
                send_byte(8'($urandom_range(8'hF1, 8'hFF)), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_byte(midi_byte, last_of_run);
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before the first header are dropped
        send_byte(8'h45, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte({HI_NOTE_ON, 4'h0}, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        // running status, then a marked byte abandons the message
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte({HI_PROG, 4'hF}, 1'b0);
        send_byte(8'h12, 1'b0);
        // system status clears running status, stray data is dropped
        send_byte(8'h81, 1'b0);
        send_byte(ST_TUNE_REQ, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(ST_CLOCK, 1'b0);
        // sysex across two packets with marked bytes inside
        send_byte(8'hFF, 1'b1);
        send_byte(8'h83, 1'b0);
        send_byte(ST_SYSEX, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h84, 1'b0);
        send_byte(ST_ACT_SENSE, 1'b0);
        send_byte(8'h85, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h86, 1'b0);
        send_byte(ST_SYSEX_END, 1'b0);
        in_valid <= 1'b0;
        wait_drained();

        while (sent < RANDOM_ITEMS + 27)
        begin
            random_packet();
            if (sent >= 600 && sent < 640)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            if (sent >= RANDOM_ITEMS - 100)
                quiet = 1'b1;
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        $display("covered %0d requests, %0d midi bytes compared, %0d sysex blocks closed",
                 sent, sb.compared, sb.sysex_closed);
        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
